[hdl/qmap_pkg.sv]
// ----------------------------------------------------------------------------
// qmap_pkg
// Shared types, constants and saturation helpers for the quadratic map
// point generator.
// ----------------------------------------------------------------------------
package qmap_pkg;

  // Number format: signed Q8.24 coordinates and coefficients
  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 24;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int ACC_W     = COORD_W + 3;   // six terms summed exactly
  localparam int NUM_COEF  = 6;

  // Configuration port
  localparam int CFG_W    = 64;
  localparam int ADDR_W   = 6;
  localparam int IDX_LSB  = 3;
  localparam int IDX_W    = 3;
  localparam int RUN_W    = 21;
  localparam logic [RUN_W-1:0] RUN_RESET = RUN_W'(1024);

  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  // Request codes
  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // Register map
  typedef enum logic [IDX_W-1:0] {
    REG_COEF_A,
    REG_COEF_B,
    REG_COEF_C,
    REG_COEF_D,
    REG_COEF_E,
    REG_COEF_F,
    REG_RUN_LENGTH
  } reg_idx_t;

  typedef struct packed {
    logic [NUM_COEF-1:0][COORD_W-1:0] cx;   // x map: const, x, xx, xy, yy, y
    logic [NUM_COEF-1:0][COORD_W-1:0] cy;   // y map, same order
    logic [RUN_W-1:0]                 run_length;
  } qmap_cfg_t;

  // Multiplier schedule
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SQ_A,    // x*x and x*y
    MUL_SQ_B,    // y*y
    MUL_T1,      // weight * x
    MUL_T2,      // weight * xx
    MUL_T3,      // weight * xy
    MUL_T4,      // weight * yy
    MUL_T5       // weight * y
  } mul_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    logic    seed;
    logic    acc_init;
    mul_op_t mul_op;
    logic    commit;
    logic    last;
  } qmap_cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] value;
    logic                      clip;
  } sat_t;

  // Product >> FRAC_BITS (floor), clipped to COORD_W signed bits
  function automatic sat_t sat_prod(input logic signed [PROD_W-1:0] p);
    sat_t r;
    logic [PROD_W-FRAC_BITS-COORD_W:0] hi;
    hi     = p[PROD_W-1:FRAC_BITS+COORD_W-1];
    r.clip = !((&hi) || !(|hi));
    if (r.clip) begin
      r.value = p[PROD_W-1] ? COORD_MIN : COORD_MAX;
    end else begin
      r.value = p[FRAC_BITS+COORD_W-1:FRAC_BITS];
    end
    return r;
  endfunction

  // Accumulated sum clipped to COORD_W signed bits
  function automatic sat_t sat_sum(input logic signed [ACC_W-1:0] a);
    sat_t r;
    logic [ACC_W-COORD_W:0] hi;
    hi     = a[ACC_W-1:COORD_W-1];
    r.clip = !((&hi) || !(|hi));
    if (r.clip) begin
      r.value = a[ACC_W-1] ? COORD_MIN : COORD_MAX;
    end else begin
      r.value = a[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_acc(input logic [COORD_W-1:0] v);
    return {{(ACC_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

endpackage

[hdl/qmap_if.sv]
// ----------------------------------------------------------------------------
// qmap_req_if / qmap_pnt_if
// Valid/ready channels for seed/step requests and generated points.
// ----------------------------------------------------------------------------
interface qmap_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic signed [qmap_pkg::COORD_W-1:0]  start_x;
  logic signed [qmap_pkg::COORD_W-1:0]  start_y;

  modport source (output valid, req_type, start_x, start_y, input ready);
  modport sink   (input valid, req_type, start_x, start_y, output ready);
endinterface

interface qmap_pnt_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qmap_pkg::COORD_W-1:0]  point_x;
  logic signed [qmap_pkg::COORD_W-1:0]  point_y;
  logic                                 last;
  logic                                 saturated;

  modport source (output valid, point_x, point_y, last, saturated, input ready);
  modport sink   (input valid, point_x, point_y, last, saturated, output ready);
endinterface

[hdl/quadratic_map_point_generator.sv]
// ----------------------------------------------------------------------------
// quadratic_map_point_generator
// Iterates the general 2-D quadratic map in signed Q8.24 with saturation.
// ----------------------------------------------------------------------------
// A seed request (req_type 0) loads the start point and restarts the run and
// returns nothing. A step request (req_type 1) produces the next point: two
// shared signed 32x32 multipliers, one per map, first form x*x, x*y and y*y,
// then one weighted term per map each cycle, followed by a drain slot and a
// commit state that saturates and writes back; the commit waits while the
// previous point is still held in the output register. The block takes one
// request at a time and must return to idle to accept the next. The point
// completing run_length is flagged last; steps after that give no point until
// the next seed. Coefficients and run_length sit in 64-bit APB registers at
// byte address 8*index.
module quadratic_map_point_generator (
  input  logic                        clk,
  input  logic                        rst,
  qmap_req_if.sink                    req,
  qmap_pnt_if.source                  pnt,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qmap_pkg::ADDR_W-1:0] paddr,
  input  logic [qmap_pkg::CFG_W-1:0]  pwdata,
  output logic [qmap_pkg::CFG_W-1:0]  prdata,
  output logic                        pready
);

  qmap_pkg::qmap_cfg_t cfg;
  qmap_pkg::qmap_cmd_t cmd;

  assign pready = 1'b1;

  qmap_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  qmap_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_type   (req.req_type),
    .req_ready  (req.ready),
    .pnt_valid  (pnt.valid),
    .pnt_ready  (pnt.ready),
    .run_length (cfg.run_length),
    .cmd        (cmd)
  );

  qmap_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .start_x   (req.start_x),
    .start_y   (req.start_y),
    .point_x   (pnt.point_x),
    .point_y   (pnt.point_y),
    .last      (pnt.last),
    .saturated (pnt.saturated)
  );

endmodule

[hdl/qmap_regs.sv]
// ----------------------------------------------------------------------------
// qmap_regs
// APB register file: six coefficient pairs and the run length.
// ----------------------------------------------------------------------------
module qmap_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qmap_pkg::ADDR_W-1:0]   paddr,
  input  logic [qmap_pkg::CFG_W-1:0]    pwdata,
  output logic [qmap_pkg::CFG_W-1:0]    prdata,
  output qmap_pkg::qmap_cfg_t           cfg
);

  logic [5:0][qmap_pkg::CFG_W-1:0] coef_reg;
  logic [qmap_pkg::RUN_W-1:0]      run_length;
  qmap_pkg::reg_idx_t              idx;
  logic                            wr_en;

  assign idx   = qmap_pkg::reg_idx_t'(paddr[qmap_pkg::IDX_LSB +: qmap_pkg::IDX_W]);
  assign wr_en = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_reg   <= '0;
      run_length <= qmap_pkg::RUN_RESET;
    end else if (wr_en) begin
      case (idx)
        qmap_pkg::REG_COEF_A:     coef_reg[0] <= pwdata;
        qmap_pkg::REG_COEF_B:     coef_reg[1] <= pwdata;
        qmap_pkg::REG_COEF_C:     coef_reg[2] <= pwdata;
        qmap_pkg::REG_COEF_D:     coef_reg[3] <= pwdata;
        qmap_pkg::REG_COEF_E:     coef_reg[4] <= pwdata;
        qmap_pkg::REG_COEF_F:     coef_reg[5] <= pwdata;
        qmap_pkg::REG_RUN_LENGTH: run_length  <= pwdata[qmap_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      qmap_pkg::REG_COEF_A:     prdata = coef_reg[0];
      qmap_pkg::REG_COEF_B:     prdata = coef_reg[1];
      qmap_pkg::REG_COEF_C:     prdata = coef_reg[2];
      qmap_pkg::REG_COEF_D:     prdata = coef_reg[3];
      qmap_pkg::REG_COEF_E:     prdata = coef_reg[4];
      qmap_pkg::REG_COEF_F:     prdata = coef_reg[5];
      qmap_pkg::REG_RUN_LENGTH: prdata = qmap_pkg::CFG_W'(run_length);
      default:                  prdata = '0;
    endcase
  end

  // Each pair register holds two coefficients, low half first
  assign cfg.cx         = {coef_reg[2], coef_reg[1], coef_reg[0]};
  assign cfg.cy         = {coef_reg[5], coef_reg[4], coef_reg[3]};
  assign cfg.run_length = run_length;

endmodule

[hdl/qmap_ctrl.sv]
// ----------------------------------------------------------------------------
// qmap_ctrl
// Sequencer: accepts requests, steps the multiplier schedule, tracks the run
// and owns the output valid.
// ----------------------------------------------------------------------------
module qmap_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_type,
  output logic                        req_ready,
  output logic                        pnt_valid,
  input  logic                        pnt_ready,
  input  logic [qmap_pkg::RUN_W-1:0]  run_length,
  output qmap_pkg::qmap_cmd_t         cmd
);

  qmap_pkg::ctrl_state_t      state, state_next;
  logic [2:0]                 cnt;
  logic [qmap_pkg::RUN_W-1:0] points_done, pd_inc;
  logic                       running;

  assign pd_inc = points_done + 1'b1;

  // State register and run bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= qmap_pkg::ST_IDLE;
      cnt         <= '0;
      points_done <= '0;
      running     <= 1'b0;
      pnt_valid   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state == qmap_pkg::ST_CALC) ? cnt + 1'b1 : '0;
      if (cmd.seed) begin
        points_done <= '0;
        running     <= 1'b1;
      end else if (cmd.commit) begin
        points_done <= pd_inc;
        if (cmd.last) running <= 1'b0;
      end
      if (cmd.commit) begin
        pnt_valid <= 1'b1;
      end else if (pnt_ready) begin
        pnt_valid <= 1'b0;
      end
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.mul_op   = qmap_pkg::MUL_NONE;
    cmd.last     = (pd_inc == '0) || (pd_inc >= run_length);
    req_ready    = (state == qmap_pkg::ST_IDLE);
    case (state)
      qmap_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req_type == qmap_pkg::REQ_SEED) begin
            cmd.seed = 1'b1;
          end else if (running) begin
            cmd.acc_init = 1'b1;
            state_next   = qmap_pkg::ST_CALC;
          end
        end
      end
      qmap_pkg::ST_CALC: begin
        // squares first, then one weighted term per cycle, last slot drains
        case (cnt)
          3'd0:    cmd.mul_op = qmap_pkg::MUL_SQ_A;
          3'd1:    cmd.mul_op = qmap_pkg::MUL_SQ_B;
          3'd2:    cmd.mul_op = qmap_pkg::MUL_T1;
          3'd3:    cmd.mul_op = qmap_pkg::MUL_T2;
          3'd4:    cmd.mul_op = qmap_pkg::MUL_T3;
          3'd5:    cmd.mul_op = qmap_pkg::MUL_T4;
          3'd6:    cmd.mul_op = qmap_pkg::MUL_T5;
          default: cmd.mul_op = qmap_pkg::MUL_NONE;
        endcase
        if (cnt == 3'd7) state_next = qmap_pkg::ST_COMMIT;
      end
      qmap_pkg::ST_COMMIT: begin
        // wait for the output register to be free
        if (!pnt_valid || pnt_ready) begin
          cmd.commit = 1'b1;
          state_next = qmap_pkg::ST_IDLE;
        end
      end
      default: state_next = qmap_pkg::ST_IDLE;
    endcase
  end

endmodule

[hdl/qmap_dp.sv]
// ----------------------------------------------------------------------------
// qmap_dp
// Datapath: current point, two registered multipliers, product scaling and
// saturation, the two map accumulators and the output register.
// ----------------------------------------------------------------------------
module qmap_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  qmap_pkg::qmap_cmd_t                 cmd,
  input  qmap_pkg::qmap_cfg_t                 cfg,
  input  logic signed [qmap_pkg::COORD_W-1:0] start_x,
  input  logic signed [qmap_pkg::COORD_W-1:0] start_y,
  output logic signed [qmap_pkg::COORD_W-1:0] point_x,
  output logic signed [qmap_pkg::COORD_W-1:0] point_y,
  output logic                                last,
  output logic                                saturated
);

  logic signed [qmap_pkg::COORD_W-1:0] cur_x, cur_y, sq_xx, sq_xy, sq_yy;
  logic signed [qmap_pkg::COORD_W-1:0] op_a1, op_a2, op_b1, op_b2;
  logic signed [qmap_pkg::PROD_W-1:0]  prod_a, prod_b;
  logic signed [qmap_pkg::ACC_W-1:0]   acc_x, acc_y;
  qmap_pkg::mul_op_t                   op_d;
  qmap_pkg::sat_t                      term_a, term_b, res_x, res_y;
  logic                                flag;

  // Operand select: both lanes form the squares, then lane A feeds the x map, lane B the y map
  always_comb begin
    op_a1 = '0;
    op_a2 = '0;
    op_b1 = '0;
    op_b2 = '0;
    case (cmd.mul_op)
      qmap_pkg::MUL_SQ_A: begin
        op_a1 = cur_x;  op_a2 = cur_x;
        op_b1 = cur_x;  op_b2 = cur_y;
      end
      qmap_pkg::MUL_SQ_B: begin
        op_a1 = cur_y;  op_a2 = cur_y;
      end
      qmap_pkg::MUL_T1: begin
        op_a1 = cfg.cx[1];  op_a2 = cur_x;
        op_b1 = cfg.cy[1];  op_b2 = cur_x;
      end
      qmap_pkg::MUL_T2: begin
        op_a1 = cfg.cx[2];  op_a2 = sq_xx;
        op_b1 = cfg.cy[2];  op_b2 = sq_xx;
      end
      qmap_pkg::MUL_T3: begin
        op_a1 = cfg.cx[3];  op_a2 = sq_xy;
        op_b1 = cfg.cy[3];  op_b2 = sq_xy;
      end
      qmap_pkg::MUL_T4: begin
        op_a1 = cfg.cx[4];  op_a2 = sq_yy;
        op_b1 = cfg.cy[4];  op_b2 = sq_yy;
      end
      qmap_pkg::MUL_T5: begin
        op_a1 = cfg.cx[5];  op_a2 = cur_y;
        op_b1 = cfg.cy[5];  op_b2 = cur_y;
      end
      default: ;
    endcase
  end

  // Registered multipliers (signed 32x32, full-width product)
  always_ff @(posedge clk) begin
    prod_a <= qmap_pkg::PROD_W'(op_a1) * qmap_pkg::PROD_W'(op_a2);
    prod_b <= qmap_pkg::PROD_W'(op_b1) * qmap_pkg::PROD_W'(op_b2);
  end

  // Op tag is registered together with the products, so it stays aligned with them
  always_ff @(posedge clk) begin
    if (rst) begin
      op_d <= qmap_pkg::MUL_NONE;
    end else begin
      op_d <= cmd.mul_op;
    end
  end

  assign term_a = qmap_pkg::sat_prod(prod_a);
  assign term_b = qmap_pkg::sat_prod(prod_b);
  assign res_x  = qmap_pkg::sat_sum(acc_x);
  assign res_y  = qmap_pkg::sat_sum(acc_y);

  // Point, squares, accumulators and output register
  always_ff @(posedge clk) begin
    if (cmd.seed) begin
      cur_x <= start_x;
      cur_y <= start_y;
    end
    if (cmd.acc_init) begin
      acc_x <= qmap_pkg::ext_acc(cfg.cx[0]);
      acc_y <= qmap_pkg::ext_acc(cfg.cy[0]);
      flag  <= 1'b0;
    end
    case (op_d)
      qmap_pkg::MUL_SQ_A: begin
        sq_xx <= term_a.value;
        sq_xy <= term_b.value;
        flag  <= flag | term_a.clip | term_b.clip;
      end
      qmap_pkg::MUL_SQ_B: begin
        sq_yy <= term_a.value;
        flag  <= flag | term_a.clip;
      end
      qmap_pkg::MUL_T1, qmap_pkg::MUL_T2, qmap_pkg::MUL_T3,
      qmap_pkg::MUL_T4, qmap_pkg::MUL_T5: begin
        acc_x <= acc_x + qmap_pkg::ext_acc(term_a.value);
        acc_y <= acc_y + qmap_pkg::ext_acc(term_b.value);
        flag  <= flag | term_a.clip | term_b.clip;
      end
      default: ;
    endcase
    if (cmd.commit) begin
      cur_x     <= res_x.value;
      cur_y     <= res_y.value;
      point_x   <= res_x.value;
      point_y   <= res_y.value;
      last      <= cmd.last;
      saturated <= flag | res_x.clip | res_y.clip;
    end
  end

endmodule

[hdl/qmap_checker.sv]
// ----------------------------------------------------------------------------
// qmap_checker
// Port-level checks for the quadratic map point generator.
// ----------------------------------------------------------------------------
module qmap_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        req_type,
  input logic                        pnt_valid,
  input logic                        pnt_ready,
  input logic [qmap_pkg::COORD_W-1:0] pnt_x,
  input logic [qmap_pkg::COORD_W-1:0] pnt_y,
  input logic                        pnt_last,
  input logic                        pnt_sat
);

  // A point offered stays offered until taken
  a_pnt_hold: assert property (@(posedge clk) disable iff (rst)
    pnt_valid && !pnt_ready |=> pnt_valid)
    else $error("point dropped before taken");

  // A stalled point keeps its payload
  a_pnt_stable: assert property (@(posedge clk) disable iff (rst)
    pnt_valid && !pnt_ready |=> $stable(pnt_x) && $stable(pnt_y) &&
                                $stable(pnt_last) && $stable(pnt_sat))
    else $error("stalled point changed");

  // No point can appear the cycle after a request is taken
  a_no_instant_pnt: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(pnt_valid))
    else $error("point appeared too early");

  // The block is ready again in the cycle after a seed is taken
  a_seed_ready: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_type == qmap_pkg::REQ_SEED) |=> req_ready)
    else $error("not ready after seed");

endmodule

bind quadratic_map_point_generator qmap_checker u_qmap_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_type  (req.req_type),
  .pnt_valid (pnt.valid),
  .pnt_ready (pnt.ready),
  .pnt_x     (pnt.point_x),
  .pnt_y     (pnt.point_y),
  .pnt_last  (pnt.last),
  .pnt_sat   (pnt.saturated)
);
